// ----- hw/rtl/ipmr_pkg.sv -----
// Package for the icon palette merge and remap block.
// Holds item types, opcodes, status codes, constants and the color packing helper.
// No dependencies.
package ipmr_pkg;

  localparam int SHARED_MAX     = 15;
  localparam int MAP_DEPTH      = 16;
  localparam int NUM_NIBBLES    = 8;
  localparam int FRAME_BYTES    = 512;
  localparam int FRAME_SHIFT    = $clog2(FRAME_BYTES);
  localparam int TOP_ROW_BASE   = 496;
  localparam int MAX_FRAMES_DEF = 3;
  localparam int ADDR_W         = 11;

  localparam logic [3:0] TRANSPARENT_IDX = 4'hf;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_ENTRY  = 2'd1,
    OP_PIXELS = 2'd2,
    OP_READ   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_UNUSED = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] color;
    logic [3:0]  entry_index;
    logic [31:0] pixel_bytes;
    logic [7:0]  transparency_mask;
    logic [4:0]  row;
    logic [1:0]  column_group;
    logic [1:0]  frame;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [3:0]        mapped_index;
    logic [3:0]        color_count;
    logic [31:0]       out_pixels;
    logic [ADDR_W-1:0] out_address;
    logic [15:0]       palette_color;
  } out_item_t;

  // Write port of the shared palette lanes
  typedef struct packed {
    logic        en;
    logic [3:0]  idx;
    logic [31:0] color;
  } pal_wr_t;

  // Write port of the index map copies
  typedef struct packed {
    logic       en;
    logic [3:0] addr;
    logic [3:0] data;
  } map_wr_t;

  // Pack ARGB8888 into ARGB4444 with alpha forced opaque
  function automatic logic [15:0] to_argb4444(input logic [31:0] c);
    logic [15:0] r;
    r = 16'hf000 | (c[27:12] & 16'h0f00) | (c[23:8] & 16'h00f0) | (c[19:4] & 16'h000f);
    return r;
  endfunction

endpackage

// ----- hw/rtl/ipmr_if.sv -----
// Valid/ready channel interfaces for the input and result items.
// Depends on ipmr_pkg for the payload types.
interface ipmr_in_if;
  logic                valid;
  logic                ready;
  ipmr_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ipmr_out_if;
  logic                valid;
  logic                ready;
  ipmr_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/ipmr_match_lane.sv -----
// One shared palette slot: holds its color and compares it against a new entry.
// Depends on ipmr_pkg.
module ipmr_match_lane #(
  parameter int LANE = 0
) (
  input  logic                clk,
  input  ipmr_pkg::pal_wr_t   wr,
  input  logic [3:0]          color_used,
  input  logic [31:0]         color,
  output logic                hit,
  output logic [31:0]         slot_color
);

  logic [31:0] slot_r;

  // Load the slot when the append targets this lane
  always_ff @(posedge clk) begin
    if (wr.en && (wr.idx == 4'(LANE))) begin
      slot_r <= wr.color;
    end
  end

  // Only slots below the fill count take part
  assign hit        = (4'(LANE) < color_used) && (slot_r == color);
  assign slot_color = slot_r;

endmodule

// ----- hw/rtl/ipmr_remap_lane.sv -----
// One pixel lane: a private copy of the index map remaps one 4-bit pixel.
// Depends on ipmr_pkg.
module ipmr_remap_lane (
  input  logic              clk,
  input  ipmr_pkg::map_wr_t wr,
  input  logic [3:0]        nibble,
  input  logic              masked,
  output logic [3:0]        mapped
);

  logic [3:0] map_r [ipmr_pkg::MAP_DEPTH];

  // Broadcast map update, every lane keeps the same contents
  always_ff @(posedge clk) begin
    if (wr.en) begin
      map_r[wr.addr] <= wr.data;
    end
  end

  // Masked pixels go transparent
  assign mapped = masked ? ipmr_pkg::TRANSPARENT_IDX : map_r[nibble];

endmodule

// ----- hw/rtl/icon_palette_merge_remap_top.sv -----
// Top level of the icon palette merge and remap block.
// Depends on ipmr_pkg, ipmr_if, ipmr_match_lane and ipmr_remap_lane.
//
//   channel   | direction | handshake          | payload
//   in_item   | sink      | valid/ready        | opcode, color, entry, pixels, mask, position
//   out_item  | source    | valid/ready        | status, index, count, pixels, address, color
//
// Each item gives one result in the next cycle; one item per cycle unless out_item stalls.
// The palette search is 15 parallel slot compares merged by a priority pick;
// the eight pixels remap in eight lanes, each with its own index map copy.
// Reset clears the color count, the full flag and the output valid.
// A stalled result holds in the output register; a new item is taken in the
// same cycle the held result leaves.
module icon_palette_merge_remap_top #(
  parameter int MAX_FRAMES = ipmr_pkg::MAX_FRAMES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  ipmr_in_if.sink    in_item,
  ipmr_out_if.source out_item
);

  localparam int NS = ipmr_pkg::SHARED_MAX;
  localparam int NN = ipmr_pkg::NUM_NIBBLES;

  logic [3:0]          color_used_r, color_used_nxt;
  logic                full_r, full_nxt;
  logic                out_valid_r;
  ipmr_pkg::out_item_t out_r, out_nxt;

  ipmr_pkg::in_item_t  it;
  logic                in_fire;
  ipmr_pkg::opcode_t   op;
  ipmr_pkg::pal_wr_t   pal_wr;
  ipmr_pkg::map_wr_t   map_wr;

  logic [NS-1:0]       hit_vec;
  logic [31:0]         slot_color [NS];
  logic                any_hit;
  logic [3:0]          hit_idx;
  logic [3:0]          lane_out [NN];
  logic [31:0]         pix_out;
  logic [1:0]          frame_sat;
  logic [11:0]         addr_full;
  logic [31:0]         rd_color;

  assign it      = in_item.data;
  assign op      = ipmr_pkg::opcode_t'(it.opcode);
  assign in_item.ready = !out_valid_r || out_item.ready;
  assign in_fire = in_item.valid && in_item.ready;

  // Palette slot lanes
  for (genvar g = 0; g < NS; g++) begin : g_slot
    ipmr_match_lane #(.LANE(g)) u_slot (
      .clk        (clk),
      .wr         (pal_wr),
      .color_used (color_used_r),
      .color      (it.color),
      .hit        (hit_vec[g]),
      .slot_color (slot_color[g])
    );
  end

  // Merge the lane compares: lowest matching slot wins
  always_comb begin
    hit_idx = '0;
    for (int j = NS - 1; j >= 0; j--) begin
      if (hit_vec[j]) begin
        hit_idx = 4'(j);
      end
    end
  end
  assign any_hit = |hit_vec;

  // Pixel lanes; nibble n is the high nibble of its byte when n is odd
  for (genvar n = 0; n < NN; n++) begin : g_pix
    localparam int MBIT = NN - 1 - (n ^ 1);
    ipmr_remap_lane u_pix (
      .clk    (clk),
      .wr     (map_wr),
      .nibble (it.pixel_bytes[4*n +: 4]),
      .masked (it.transparency_mask[MBIT]),
      .mapped (lane_out[n])
    );
    assign pix_out[4*n +: 4] = lane_out[n];
  end

  // Row-flipped address with the frame saturated
  assign frame_sat = (it.frame >= 2'(MAX_FRAMES)) ? 2'(MAX_FRAMES - 1) : it.frame;
  assign addr_full = (12'(frame_sat) << ipmr_pkg::FRAME_SHIFT)
                   + 12'(ipmr_pkg::TOP_ROW_BASE)
                   - {3'b000, it.row, 4'b0000}
                   + {8'h00, it.column_group, 2'b00};

  assign rd_color = (it.entry_index < 4'(NS)) ? slot_color[it.entry_index] : '0;

  // Next state and result
  always_comb begin
    color_used_nxt = color_used_r;
    full_nxt       = full_r;
    pal_wr         = '0;
    map_wr         = '0;
    out_nxt        = '0;
    unique case (op)
      ipmr_pkg::OP_CLEAR: begin
        color_used_nxt = '0;
        full_nxt       = 1'b0;
      end
      ipmr_pkg::OP_ENTRY: begin
        if (!full_r) begin
          if (any_hit) begin
            map_wr.en            = in_fire;
            map_wr.addr          = it.entry_index;
            map_wr.data          = hit_idx;
            out_nxt.mapped_index = hit_idx;
          end else if (color_used_r >= 4'(NS)) begin
            full_nxt = 1'b1;
          end else begin
            pal_wr.en            = in_fire;
            pal_wr.idx           = color_used_r;
            pal_wr.color         = it.color;
            map_wr.en            = in_fire;
            map_wr.addr          = it.entry_index;
            map_wr.data          = color_used_r;
            out_nxt.mapped_index = color_used_r;
            color_used_nxt       = color_used_r + 4'd1;
          end
        end
      end
      ipmr_pkg::OP_PIXELS: begin
        out_nxt.out_pixels  = pix_out;
        out_nxt.out_address = addr_full[ipmr_pkg::ADDR_W-1:0];
      end
      ipmr_pkg::OP_READ: begin
        if (it.entry_index == ipmr_pkg::TRANSPARENT_IDX) begin
          out_nxt.palette_color = '0;
        end else if (it.entry_index < color_used_r) begin
          out_nxt.palette_color = ipmr_pkg::to_argb4444(rd_color);
        end else begin
          out_nxt.status = ipmr_pkg::ST_UNUSED;
        end
      end
      default: begin
        out_nxt = '0;
      end
    endcase
    if (full_nxt) begin
      out_nxt.status = ipmr_pkg::ST_FULL;
    end
    out_nxt.color_count = color_used_nxt;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_used_r <= '0;
      full_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_fire) begin
        color_used_r <= color_used_nxt;
        full_r       <= full_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_item.ready) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  // Result register; hold while stalled
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_r <= out_nxt;
    end
  end

  assign out_item.valid = out_valid_r;
  assign out_item.data  = out_r;

  // Full flag only ever stands with all fifteen slots in use
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    full_r |-> (color_used_r == 4'(NS)))
    else $error("full flag set with free palette slots");

  // Clear empties the palette and drops the error
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (op == ipmr_pkg::OP_CLEAR)) |=> ((color_used_r == '0) && !full_r))
    else $error("clear did not reset palette state");

  // Live slots hold distinct colors, so at most one lane matches
  a_unique_hit: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(hit_vec))
    else $error("several palette slots match one color");

  // A held result reports full exactly when the flag is set
  a_status_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_r.status == ipmr_pkg::ST_FULL) == full_r))
    else $error("result status disagrees with full flag");

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for icon_palette_merge_remap_top.
// Depends on ipmr_pkg and the ipmr_in_if / ipmr_out_if channel interfaces.
// Predicts each result from its own palette merge model and compares field by field.
module testbench;

  localparam int FRAMES       = ipmr_pkg::MAX_FRAMES_DEF;
  localparam int LIMIT_CYCLES = 200000;
  localparam int MAX_REPORTS  = 10;
  localparam int DRAIN_CYCLES = 8;
  localparam int POOL_SIZE    = 8;

  logic clk = 1'b0;
  logic rst_n;

  ipmr_in_if  in_ch ();
  ipmr_out_if out_ch ();

  icon_palette_merge_remap_top #(
    .MAX_FRAMES (FRAMES)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_ch),
    .out_item (out_ch)
  );

  // Shadow copy of the block state
  logic [31:0]                    shared_colors [ipmr_pkg::SHARED_MAX];
  logic [3:0]                     colors_in_use;
  logic [3:0]                     entry_map [ipmr_pkg::MAP_DEPTH];
  logic [ipmr_pkg::MAP_DEPTH-1:0] map_written;
  logic                           palette_full;

  ipmr_pkg::out_item_t pending_results [$];
  logic [31:0]         color_pool [POOL_SIZE];
  int                  mismatches;
  int                  cycle_count;
  int                  items_sent;
  int                  send_idle_pct;
  int                  recv_stall_pct;

  // Clock: period 2
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Compute the expected result of one item and advance the shadow state
  function automatic ipmr_pkg::out_item_t merge_and_remap(input ipmr_pkg::in_item_t it);
    ipmr_pkg::out_item_t r;
    int          hit;
    int          f;
    int          pos;
    int          addr_sum;
    logic [3:0]  nib;
    logic [31:0] c;
    r = '0;
    case (ipmr_pkg::opcode_t'(it.opcode))
      ipmr_pkg::OP_CLEAR: begin
        colors_in_use = '0;
        palette_full  = 1'b0;
      end
      ipmr_pkg::OP_ENTRY: begin
        if (!palette_full) begin
          hit = -1;
          for (int j = 0; j < ipmr_pkg::SHARED_MAX; j++) begin
            if (hit < 0 && j < colors_in_use && shared_colors[j] == it.color) hit = j;
          end
          if (hit >= 0) begin
            entry_map[it.entry_index]   = 4'(hit);
            map_written[it.entry_index] = 1'b1;
            r.mapped_index              = 4'(hit);
          end else if (colors_in_use == ipmr_pkg::SHARED_MAX) begin
            // sixteenth distinct color: flag and leave the map alone
            palette_full = 1'b1;
          end else begin
            shared_colors[colors_in_use] = it.color;
            entry_map[it.entry_index]    = colors_in_use;
            map_written[it.entry_index]  = 1'b1;
            r.mapped_index               = colors_in_use;
            colors_in_use                = colors_in_use + 4'd1;
          end
        end
      end
      ipmr_pkg::OP_PIXELS: begin
        // pixel k sits in byte k/2, high nibble first; mask bit 7-k
        for (int k = 0; k < ipmr_pkg::NUM_NIBBLES; k++) begin
          pos = 8 * (k / 2) + ((k % 2 == 0) ? 4 : 0);
          nib = it.pixel_bytes[pos +: 4];
          r.out_pixels[pos +: 4] = it.transparency_mask[7-k] ? ipmr_pkg::TRANSPARENT_IDX
                                                             : entry_map[nib];
        end
        f = int'(it.frame);
        if (f >= FRAMES) f = FRAMES - 1;
        addr_sum = f * ipmr_pkg::FRAME_BYTES + ipmr_pkg::TOP_ROW_BASE
                   - 16 * int'(it.row) + 4 * int'(it.column_group);
        r.out_address = addr_sum[ipmr_pkg::ADDR_W-1:0];
      end
      ipmr_pkg::OP_READ: begin
        if (it.entry_index == ipmr_pkg::TRANSPARENT_IDX) begin
          r.palette_color = '0;
        end else if (it.entry_index < colors_in_use) begin
          c = shared_colors[it.entry_index];
          r.palette_color = {4'hf, c[23:20], c[15:12], c[7:4]};
        end else begin
          r.status = ipmr_pkg::ST_UNUSED;
        end
      end
      default: ;
    endcase
    if (palette_full) r.status = ipmr_pkg::ST_FULL;
    r.color_count = colors_in_use;
    return r;
  endfunction

  // Random item with every field filled, then forced to the given opcode
  function automatic ipmr_pkg::in_item_t random_item(input ipmr_pkg::opcode_t op);
    ipmr_pkg::in_item_t it;
    it.opcode            = op;
    it.color             = $urandom;
    it.entry_index       = 4'($urandom_range(15));
    it.pixel_bytes       = $urandom;
    it.transparency_mask = 8'($urandom);
    it.row               = 5'($urandom_range(31));
    it.column_group      = 2'($urandom_range(3));
    it.frame             = 2'($urandom_range(3));
    return it;
  endfunction

  // Pixel group that only reads map entries already written
  function automatic ipmr_pkg::in_item_t pixel_item();
    ipmr_pkg::in_item_t it;
    int                 pos;
    logic [3:0]         nib;
    it = random_item(ipmr_pkg::OP_PIXELS);
    if ($urandom_range(1) == 0) it.transparency_mask = 8'h00;
    for (int k = 0; k < ipmr_pkg::NUM_NIBBLES; k++) begin
      pos = 8 * (k / 2) + ((k % 2 == 0) ? 4 : 0);
      if (!it.transparency_mask[7-k]) begin
        if (map_written == '0) begin
          it.transparency_mask[7-k] = 1'b1;
        end else begin
          do nib = 4'($urandom_range(15)); while (!map_written[nib]);
          it.pixel_bytes[pos +: 4] = nib;
        end
      end
    end
    return it;
  endfunction

  // Send one item, honoring the sender idle rate, and record its expected result
  task automatic issue_item(input ipmr_pkg::in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(merge_and_remap(it));
    items_sent++;
    @(negedge clk);
  endtask

  task automatic issue_op(input ipmr_pkg::opcode_t op, input logic [3:0] idx,
                          input logic [31:0] color);
    ipmr_pkg::in_item_t it;
    it             = random_item(op);
    it.entry_index = idx;
    it.color       = color;
    issue_item(it);
  endtask

  task automatic issue_pixels(input logic [31:0] pix, input logic [7:0] mask,
                              input logic [4:0] row, input logic [1:0] grp,
                              input logic [1:0] frame);
    ipmr_pkg::in_item_t it;
    it                   = random_item(ipmr_pkg::OP_PIXELS);
    it.pixel_bytes       = pix;
    it.transparency_mask = mask;
    it.row               = row;
    it.column_group      = grp;
    it.frame             = frame;
    issue_item(it);
  endtask

  // Reads and a fully masked group straight out of reset
  task automatic test_reset_state();
    issue_op(ipmr_pkg::OP_READ, 4'd0, '0);
    issue_op(ipmr_pkg::OP_READ, ipmr_pkg::TRANSPARENT_IDX, '0);
    issue_pixels(32'hffff_ffff, 8'hff, 5'd31, 2'd3, 2'd3);
  endtask

  // Fill all fifteen colors, hit a repeat, overflow, then clear
  task automatic test_palette_overflow();
    issue_op(ipmr_pkg::OP_CLEAR, '0, '0);
    for (int e = 0; e < ipmr_pkg::SHARED_MAX; e++) begin
      issue_op(ipmr_pkg::OP_ENTRY, 4'(e),
               (e == 1) ? 32'hffff_ffff : 32'(e) * 32'h0101_0101);
    end
    issue_op(ipmr_pkg::OP_ENTRY, 4'd15, 32'hffff_ffff);
    issue_op(ipmr_pkg::OP_ENTRY, 4'd3, 32'hdead_beef);
    issue_op(ipmr_pkg::OP_ENTRY, 4'd4, 32'h0000_0000);
    issue_op(ipmr_pkg::OP_READ, 4'd1, '0);
    issue_pixels(32'h0123_4567, 8'h00, 5'd0, 2'd0, 2'd0);
    issue_op(ipmr_pkg::OP_CLEAR, '0, '0);
    issue_op(ipmr_pkg::OP_READ, 4'd14, '0);
  endtask

  // Address and mask extremes over the kept index map
  task automatic test_pixel_extremes();
    issue_op(ipmr_pkg::OP_ENTRY, 4'd7, 32'h89ab_cdef);
    issue_pixels(32'h0000_0000, 8'h00, 5'd31, 2'd3, 2'd2);
    issue_pixels(32'hffff_ffff, 8'h55, 5'd16, 2'd1, 2'd1);
  endtask

  // Frame palettes with shared colors, pixel streams, reads and some noise
  task automatic test_random_frames(input int n_items, input int send_pct,
                                    input int stall_pct);
    int                 target;
    int                 frames;
    int                 reuse_pct;
    int                 groups;
    ipmr_pkg::in_item_t it;
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    target = items_sent + n_items;
    while (items_sent < target) begin
      if ($urandom_range(99) < 85) begin
        if ($urandom_range(3) != 0) issue_op(ipmr_pkg::OP_CLEAR, '0, '0);
        frames    = $urandom_range(1, FRAMES);
        reuse_pct = $urandom_range(30, 95);
        for (int p = 0; p < POOL_SIZE; p++) color_pool[p] = $urandom;
        for (int f = 0; f < frames; f++) begin
          for (int e = 0; e < ipmr_pkg::MAP_DEPTH; e++) begin
            issue_op(ipmr_pkg::OP_ENTRY, 4'(e), ($urandom_range(99) < reuse_pct)
                     ? color_pool[$urandom_range(POOL_SIZE-1)] : $urandom);
          end
          groups = $urandom_range(4, 24);
          for (int g = 0; g < groups; g++) begin
            if ($urandom_range(99) < 15) begin
              issue_item(random_item(ipmr_pkg::OP_READ));
            end else begin
              it = pixel_item();
              if ($urandom_range(9) != 0) it.frame = 2'(f);
              issue_item(it);
            end
          end
        end
      end else begin
        // noise: any opcode in any order
        repeat (8) begin
          it = random_item(ipmr_pkg::opcode_t'($urandom_range(3)));
          if (it.opcode == ipmr_pkg::OP_PIXELS) it = pixel_item();
          issue_item(it);
        end
      end
    end
  endtask

  // Receiver stalls at its current rate
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic flag_error(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("mismatch: %s", msg);
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) flag_error($sformatf("%s expected %0h got %0h", name, want, got));
  endtask

  // Check each result against the oldest expectation
  always @(posedge clk) begin : check_results
    ipmr_pkg::out_item_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        flag_error("result with no item waiting");
      end else begin
        want = pending_results.pop_front();
        compare_field("status", want.status, out_ch.data.status);
        compare_field("mapped_index", want.mapped_index, out_ch.data.mapped_index);
        compare_field("color_count", want.color_count, out_ch.data.color_count);
        compare_field("out_pixels", want.out_pixels, out_ch.data.out_pixels);
        compare_field("out_address", want.out_address, out_ch.data.out_address);
        compare_field("palette_color", want.palette_color, out_ch.data.palette_color);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  initial begin
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.data     = '0;
    out_ch.ready   = 1'b0;
    colors_in_use  = '0;
    palette_full   = 1'b0;
    map_written    = '0;
    mismatches     = 0;
    cycle_count    = 0;
    items_sent     = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_palette_overflow();
    test_pixel_extremes();
    test_random_frames(400, 0, 0);
    test_random_frames(400, 45, 0);
    test_random_frames(400, 0, 45);
    test_random_frames(400, 22, 22);

    // Drain outstanding results, then watch for strays
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/ipmr_pkg.sv
hw/rtl/ipmr_if.sv
hw/rtl/ipmr_match_lane.sv
hw/rtl/ipmr_remap_lane.sv
hw/rtl/icon_palette_merge_remap_top.sv
dv/testbench.sv
